### hw/rtl/vwr_pkg.sv
// Package for the variable window RMS core: sizes, state encoding, control structs.
`timescale 1ns / 1ps
`default_nettype none
package vwr_pkg;

	localparam int CAPACITY_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int WS_BITS         = 11;
	localparam int OFF_BITS        = 10;
	localparam int RMS_BITS        = 16;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_W_LVL,
		ST_W_ADD,
		ST_Q_RD,
		ST_Q_ACC,
		ST_DIV_INIT,
		ST_DIV,
		ST_SQ_INIT,
		ST_SQ,
		ST_FIN
	} vwr_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clr_step;
		logic load;
		logic w_rd;
		logic w_add;
		logic q_rd;
		logic q_acc;
		logic div_start;
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic out_load;
	} vwr_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic is_query;
		logic bad;
		logic w_more;
		logic rem_zero;
		logic div_last;
		logic sqrt_last;
		logic out_busy;
	} vwr_status_t;

endpackage
`default_nettype wire

### hw/rtl/vwr_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module vwr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/vwr_ctrl.sv
// Controller state machine of the variable window RMS core.
`timescale 1ns / 1ps
`default_nettype none
module vwr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire vwr_pkg::vwr_status_t sts,
	output vwr_pkg::vwr_cmd_t         ctl
);
	import vwr_pkg::*;

	vwr_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					if (!sts.is_query) state_d = ST_W_LVL;
					else if (sts.bad) state_d = ST_FIN;
					else state_d = ST_Q_RD;
				end
			end
			ST_W_LVL:    state_d = sts.w_more ? ST_W_ADD : ST_IDLE;
			ST_W_ADD:    state_d = ST_W_LVL;
			ST_Q_RD:     state_d = ST_Q_ACC;
			ST_Q_ACC:    state_d = sts.rem_zero ? ST_DIV_INIT : ST_Q_RD;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV:      if (sts.div_last) state_d = ST_SQ_INIT;
			ST_SQ_INIT:  state_d = ST_SQ;
			ST_SQ:       if (sts.sqrt_last) state_d = ST_FIN;
			ST_FIN:      if (!sts.out_busy) state_d = ST_IDLE;
			default:     state_d = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		ctl      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: ctl.clr_step = 1'b1;
			ST_IDLE: begin
				in_stall = 1'b0;
				ctl.load = in_valid;
			end
			ST_W_LVL:    ctl.w_rd = 1'b1;
			ST_W_ADD:    ctl.w_add = 1'b1;
			ST_Q_RD:     ctl.q_rd = 1'b1;
			ST_Q_ACC:    ctl.q_acc = 1'b1;
			ST_DIV_INIT: ctl.div_start = 1'b1;
			ST_DIV:      ctl.div_step = 1'b1;
			ST_SQ_INIT:  ctl.sqrt_start = 1'b1;
			ST_SQ:       ctl.sqrt_step = 1'b1;
			ST_FIN:      ctl.out_load = !sts.out_busy;
			default:     ctl = '0;
		endcase
	end

endmodule
`default_nettype wire

### hw/rtl/vwr_datapath.sv
// Datapath: square ring, partial sum pyramid, query walk, divider, square root, output.
`timescale 1ns / 1ps
`default_nettype none
module vwr_datapath #(
	parameter int CAPACITY    = vwr_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = vwr_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire vwr_pkg::vwr_cmd_t                 ctl,
	output vwr_pkg::vwr_status_t                   sts,
	input  wire logic                              cmd,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample,
	input  wire logic [vwr_pkg::WS_BITS-1:0]       window_size,
	input  wire logic [vwr_pkg::OFF_BITS-1:0]      offset,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [vwr_pkg::RMS_BITS-1:0]           rms,
	output logic                                   bad_window
);
	import vwr_pkg::*;

	localparam int SB  = SAMPLE_BITS;
	localparam int AW  = $clog2(CAPACITY);
	localparam int LOG = AW;
	localparam int LVW = $clog2(LOG + 1);
	localparam int SQW = 2 * SB - 1;
	localparam int PW  = SQW + LOG - 1;
	localparam int SW  = SQW + LOG;
	localparam int DCW = $clog2(SW + 1);
	localparam int SCW = $clog2(SB + 1);

	// address of a pyramid cell of level l covering position p
	function automatic logic [AW-1:0] pidx(input logic [LVW-1:0] l, input logic [AW-1:0] p);
		logic [AW:0] base;
		base = (AW+1)'(CAPACITY) - ((AW+1)'(CAPACITY) >> (l - LVW'(1)));
		return AW'(base + (AW+1)'(p >> l));
	endfunction

	logic [AW-1:0]       wp_q, clr_addr_q, cur_q;
	logic [LVW-1:0]      lvl_q, best;
	logic [PW-1:0]       a_q;
	logic [SW-1:0]       sum_q, dq_q;
	logic [WS_BITS-1:0]  rem_q, ws_q;
	logic                bad_q, src_q, out_valid_q;
	logic [WS_BITS:0]    dr_q, dt;
	logic [DCW-1:0]      dcnt_q;
	logic [SCW-1:0]      scnt_q;
	logic [2*SB-1:0]     sv_q;
	logic [SB+1:0]       sr_q, st, strial;
	logic [SB-1:0]       root_q, mag;
	logic [RMS_BITS-1:0] rms_q;
	logic                bad_out_q;

	logic            sq_we, p_we;
	logic [AW-1:0]   sq_waddr, sq_raddr, p_waddr, p_raddr, wp_next;
	logic [SQW-1:0]  sq_wdata, sq_rdata;
	logic [PW-1:0]   p_wdata, p_rdata, w_sum;
	logic [AW-1:0]   half;

	// magnitude of the incoming sample, squared where it is stored
	assign mag     = sample[SB-1] ? (~sample + SB'(1)) : sample;
	assign wp_next = wp_q + AW'(1);
	assign half    = AW'(32'd1 << (lvl_q - LVW'(1)));
	assign w_sum   = a_q + ((lvl_q == LVW'(1)) ? PW'(sq_rdata) : p_rdata);

	// largest aligned cell that fits in the remaining length
	always_comb begin
		logic [AW-1:0] m;
		best = '0;
		for (int l = 1; l < LOG; l++) begin
			m = AW'((32'd1 << l) - 1);
			if (((cur_q & m) == m) && ((rem_q >> l) != '0)) best = LVW'(l);
		end
	end

	// RAM port selection
	always_comb begin
		sq_we    = ctl.clr_step || (ctl.load && !cmd);
		sq_waddr = ctl.clr_step ? clr_addr_q : wp_next;
		sq_wdata = ctl.clr_step ? '0 : SQW'(mag * mag);
		sq_raddr = ctl.q_rd ? cur_q : (wp_q - AW'(1));
		p_we     = ctl.clr_step || ctl.w_add;
		p_waddr  = ctl.clr_step ? clr_addr_q : pidx(lvl_q, wp_q);
		p_wdata  = ctl.clr_step ? '0 : w_sum;
		p_raddr  = ctl.q_rd ? pidx(best, cur_q) : pidx(lvl_q - LVW'(1), wp_q - half);
	end

	vwr_ram #(.WIDTH(SQW), .DEPTH(CAPACITY)) u_sq_ram (
		.clk(clk), .we(sq_we), .waddr(sq_waddr), .wdata(sq_wdata),
		.raddr(sq_raddr), .rdata(sq_rdata)
	);

	vwr_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_p_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
			if (ctl.load && !cmd) wp_q <= wp_next;
			if (ctl.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q   <= PW'(SQW'(mag * mag));
			lvl_q <= LVW'(1);
			cur_q <= wp_q - AW'(offset);
			rem_q <= window_size;
			ws_q  <= window_size;
			sum_q <= '0;
			bad_q <= cmd && ((window_size == '0) ||
				((32'(window_size) + 32'(offset)) > 32'(CAPACITY)));
		end
		if (ctl.w_add) begin
			a_q   <= w_sum;
			lvl_q <= lvl_q + LVW'(1);
		end
		if (ctl.q_rd) begin
			rem_q <= rem_q - (WS_BITS'(1) << best);
			cur_q <= cur_q - (AW'(1) << best);
			src_q <= (best != '0);
		end
		if (ctl.q_acc) sum_q <= sum_q + (src_q ? SW'(p_rdata) : SW'(sq_rdata));
		// restoring divider, one quotient bit a cycle
		if (ctl.div_start) begin
			dq_q   <= sum_q;
			dr_q   <= '0;
			dcnt_q <= DCW'(SW);
		end
		if (ctl.div_step) begin
			if (dt >= {1'b0, ws_q}) begin
				dr_q <= dt - {1'b0, ws_q};
				dq_q <= {dq_q[SW-2:0], 1'b1};
			end else begin
				dr_q <= dt;
				dq_q <= {dq_q[SW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q - DCW'(1);
		end
		// digit by digit square root, one root bit a cycle
		if (ctl.sqrt_start) begin
			sv_q   <= (2*SB)'(dq_q);
			sr_q   <= '0;
			root_q <= '0;
			scnt_q <= SCW'(SB);
		end
		if (ctl.sqrt_step) begin
			sv_q <= {sv_q[2*SB-3:0], 2'b00};
			if (st >= strial) begin
				sr_q   <= st - strial;
				root_q <= {root_q[SB-2:0], 1'b1};
			end else begin
				sr_q   <= st;
				root_q <= {root_q[SB-2:0], 1'b0};
			end
			scnt_q <= scnt_q - SCW'(1);
		end
		if (ctl.out_load) begin
			rms_q     <= bad_q ? '0 : RMS_BITS'(root_q);
			bad_out_q <= bad_q;
		end
	end

	assign dt     = {dr_q[WS_BITS-1:0], dq_q[SW-1]};
	assign st     = {sr_q[SB-1:0], sv_q[2*SB-1 -: 2]};
	assign strial = {root_q, 2'b01};

	// status
	always_comb begin
		logic [AW-1:0] m;
		m             = AW'((32'd1 << lvl_q) - 1);
		sts           = '0;
		sts.clr_last  = (clr_addr_q == '1);
		sts.is_query  = cmd;
		sts.bad       = cmd && ((window_size == '0) ||
			((32'(window_size) + 32'(offset)) > 32'(CAPACITY)));
		sts.w_more    = (32'(lvl_q) < LOG) && ((wp_q & m) == m);
		sts.rem_zero  = (rem_q == '0);
		sts.div_last  = (dcnt_q == DCW'(1));
		sts.sqrt_last = (scnt_q == SCW'(1));
		sts.out_busy  = out_valid_q && out_stall;
	end

	assign out_valid  = out_valid_q;
	assign rms        = rms_q;
	assign bad_window = bad_out_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !(out_valid_q && out_stall))
		else $error("result overwritten while waiting");
	a_mean_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sqrt_start |-> ((dq_q >> SQW) == '0))
		else $error("mean wider than a square");
	a_walk_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.q_rd |-> (rem_q != '0) && (rem_q <= ws_q))
		else $error("query walk past window");
`endif

endmodule
`default_nettype wire

### hw/rtl/variable_window_rms_core.sv
// Top level of the variable window RMS core.
//
// Input channel (in_valid/in_stall): cmd 0 writes a signed sample into the
// ring and updates the partial sum pyramid; cmd 1 queries the RMS of
// window_size samples ending offset samples behind the newest write.
// A write gives no result; a query gives one request on the output channel
// (out_valid/out_stall) carrying rms and bad_window.
// A write stores the square of the sample, then adds up one pyramid level
// after another for each level it completes. A query is accepted, walks
// the cells that cover the window (up to about 2*log2(CAPACITY) cells),
// divides the SW-bit sum by window_size in the bit-serial divider
// (SW = 2*SAMPLE_BITS-1+log2(CAPACITY)), takes the bit-serial square root
// and loads the output register. A rejected window skips the walk, divider
// and square root. After reset a clearing pass zeroes both stores with
// in_stall high. A finished result sits in the output register; the core
// keeps taking writes while the receiver stalls and waits only when a new
// query result is ready and the previous one has not been taken.
`timescale 1ns / 1ps
`default_nettype none
module variable_window_rms_core #(
	parameter int CAPACITY    = vwr_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = vwr_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          cmd,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic [vwr_pkg::WS_BITS-1:0]   window_size,
	input  wire logic [vwr_pkg::OFF_BITS-1:0]  offset,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [vwr_pkg::RMS_BITS-1:0]       rms,
	output logic                               bad_window
);
	import vwr_pkg::*;

	vwr_cmd_t    ctl;
	vwr_status_t sts;

	vwr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .ctl(ctl)
	);

	vwr_datapath #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.cmd(cmd), .sample(sample), .window_size(window_size), .offset(offset),
		.out_valid(out_valid), .out_stall(out_stall), .rms(rms),
		.bad_window(bad_window)
	);

endmodule
`default_nettype wire
